/* hw/rtl/lcgmt_pkg.sv */
package lcgmt_pkg;

    // Single generator step: s' = s * LCG_MUL + LCG_ADD (mod 2^32)
    localparam logic [31:0] LCG_MUL  = 32'd1103515245;
    localparam logic [31:0] LCG_ADD  = 32'd12345;

    // Three steps folded into one affine map: s''' = s * LCG_MUL3 + LCG_ADD3
    localparam logic [31:0] LCG_MUL2 = LCG_MUL * LCG_MUL;
    localparam logic [31:0] LCG_MUL3 = LCG_MUL2 * LCG_MUL;
    localparam logic [31:0] LCG_ADD3 = LCG_ADD * (LCG_MUL2 + LCG_MUL + 32'd1);

    // Request codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_CHECK = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SEED   = 2'd0;
    localparam logic [1:0] CFG_BASE   = 2'd1;
    localparam logic [1:0] CFG_LENGTH = 2'd2;

    localparam logic [31:0] SEED_RESET = 32'd1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] read_byte;
    } req_item_t;

    typedef struct packed {
        logic [31:0] address;
        logic [7:0]  pattern_byte;
        logic        mismatch;
        logic        last;
        logic        overrun;
    } rsp_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;  // latch request, start the multiply
        logic emit;     // update generator state, load result register
    } ctrl_cmd_t;

endpackage

/* hw/rtl/lcgmt_ctrl.sv */
module lcgmt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output lcgmt_pkg::ctrl_cmd_t cmd
);

    lcgmt_pkg::ctrl_state_t state_reg, state_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic                   rsp_free;

    // Result slot can take a new item when empty or drained this cycle
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lcgmt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lcgmt_pkg::ST_EMIT;
                end
            end
            lcgmt_pkg::ST_EMIT:
            begin
                if (rsp_free)
                begin
                    state_next = lcgmt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcgmt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall   = 1'b1;
        cmd.capture = 1'b0;
        cmd.emit    = 1'b0;
        unique case (state_reg)
            lcgmt_pkg::ST_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            lcgmt_pkg::ST_EMIT:
            begin
                cmd.emit = rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign rsp_valid_next = cmd.emit | (rsp_valid_reg & rsp_stall);
    assign rsp_valid      = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcgmt_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

/* hw/rtl/lcgmt_datapath.sv */
module lcgmt_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcgmt_pkg::ctrl_cmd_t cmd,
    input  lcgmt_pkg::req_item_t req_item,
    output lcgmt_pkg::rsp_item_t rsp_item,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    logic [31:0] seed_reg, base_reg, length_reg;
    logic [31:0] gen_reg, gen_next;
    logic [31:0] idx_reg, idx_next;
    logic [31:0] prod_reg;
    lcgmt_pkg::req_item_t req_reg;
    lcgmt_pkg::rsp_item_t rsp_reg, rsp_next;

    logic [31:0] state3;
    logic [31:0] idx_inc;
    logic [7:0]  pattern;

    assign state3  = prod_reg + lcgmt_pkg::LCG_ADD3;
    assign pattern = state3[23:16];
    assign idx_inc = idx_reg + 32'd1;

    always_comb
    begin
        gen_next = gen_reg;
        idx_next = idx_reg;
        rsp_next = '0;
        unique case (req_reg.req_type) inside
            lcgmt_pkg::REQ_START:
            begin
                gen_next         = seed_reg;
                idx_next         = '0;
                rsp_next.address = base_reg;
            end
            lcgmt_pkg::REQ_WRITE, lcgmt_pkg::REQ_CHECK:
            begin
                if (idx_reg >= length_reg)
                begin
                    rsp_next.overrun = 1'b1;
                end
                else
                begin
                    gen_next              = state3;
                    idx_next              = idx_inc;
                    rsp_next.address      = base_reg + idx_reg;
                    rsp_next.pattern_byte = pattern;
                    rsp_next.last         = (idx_inc == length_reg);
                    rsp_next.mismatch     = (req_reg.req_type == lcgmt_pkg::REQ_CHECK)
                                            && (req_reg.read_byte != pattern);
                end
            end
            default:
            begin
                rsp_next = '0;  // unused selector: no state change
            end
        endcase
    end

    // Architectural state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= lcgmt_pkg::SEED_RESET;
            base_reg   <= '0;
            length_reg <= '0;
            gen_reg    <= lcgmt_pkg::SEED_RESET;
            idx_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    lcgmt_pkg::CFG_SEED:   seed_reg   <= cfg_data;
                    lcgmt_pkg::CFG_BASE:   base_reg   <= cfg_data;
                    lcgmt_pkg::CFG_LENGTH: length_reg <= cfg_data;
                    default:               ;
                endcase
            end
            if (cmd.emit)
            begin
                gen_reg <= gen_next;
                idx_reg <= idx_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req_item;
            prod_reg <= gen_reg * lcgmt_pkg::LCG_MUL3;
        end
        if (cmd.emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_item = rsp_reg;

endmodule

/* hw/rtl/lcg_memory_pattern_tester.sv */
// Pseudo-random memory test pattern engine.
//
// Channels: req (req_valid/req_stall/req_item) carries one request item:
// start (reseed and clear the byte index), write step or check step.
// rsp (rsp_valid/rsp_stall/rsp_item) returns exactly one result item per
// request: address, pattern byte, mismatch, last and overrun flags.
// An item moves on a rising edge with valid high and stall low.
// cfg_write/cfg_index/cfg_data write seed, base address and test length;
// write only while no request is in flight.
//
// Timing: a request is taken in the idle cycle, the folded three-step
// generator multiply runs in that cycle into a register, and the result is
// loaded into the output register from the emit state once the result slot
// is free. The engine takes no new request until that load is done, since
// req_stall is high in the emit state.
//
// A stalled receiver holds the result in the output register; the engine
// still takes the next request and parks it until the slot drains.
// Reset: seed 1, base 0, length 0, generator state 1, index 0, no result.
module lcg_memory_pattern_tester (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  lcgmt_pkg::req_item_t req_item,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output lcgmt_pkg::rsp_item_t rsp_item,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    lcgmt_pkg::ctrl_cmd_t cmd;

    // Sequencer: idle/emit handshake control and result-slot valid
    lcgmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    // Generator, byte index, config registers and result register
    lcgmt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_item  (req_item),
        .rsp_item  (rsp_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

/* verif/pattern_step_checker.sv */
module pattern_step_checker
    import lcgmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_item_t   req_item,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_item_t   rsp_item,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          error_count,
    output int          outstanding
);

    rsp_item_t   expected_steps[$];

    logic [31:0] seed_reg;
    logic [31:0] base_reg;
    logic [31:0] length_reg;
    logic [31:0] lcg_state;
    logic [31:0] byte_idx;

    // Applies one item to the shadow generator and returns its result.
    function automatic rsp_item_t advance_pattern(input req_item_t it);
        rsp_item_t   r;
        logic [31:0] s;
        r = '0;
        case (it.req_type)
            REQ_START:
            begin
                lcg_state = seed_reg;
                byte_idx  = '0;
                r.address = base_reg;
            end
            REQ_WRITE, REQ_CHECK:
            begin
                if (byte_idx >= length_reg)
                begin
                    r.overrun = 1'b1;
                end
                else
                begin
                    s = lcg_state;
                    repeat (3) s = s * LCG_MUL + LCG_ADD;
                    lcg_state      = s;
                    r.pattern_byte = s[23:16];
                    r.address      = base_reg + byte_idx;
                    r.last         = (byte_idx + 32'd1 == length_reg);
                    r.mismatch     = (it.req_type == REQ_CHECK) && (it.read_byte != s[23:16]);
                    byte_idx       = byte_idx + 32'd1;
                end
            end
            default: ;  // unused selector: all-zero result
        endcase
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_item_t want;
        if (!rst_n)
        begin
            seed_reg    = SEED_RESET;
            base_reg    = '0;
            length_reg  = '0;
            lcg_state   = 32'd1;
            byte_idx    = '0;
            error_count = 0;
            expected_steps.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_steps.size() == 0)
                begin
                    $error("result with no item pending: address 0x%0h", rsp_item.address);
                    error_count++;
                end
                else
                begin
                    want = expected_steps.pop_front();
                    compare_field("address", want.address, rsp_item.address);
                    compare_field("pattern_byte", 32'(want.pattern_byte),
                                  32'(rsp_item.pattern_byte));
                    compare_field("mismatch", 32'(want.mismatch), 32'(rsp_item.mismatch));
                    compare_field("last", 32'(want.last), 32'(rsp_item.last));
                    compare_field("overrun", 32'(want.overrun), 32'(rsp_item.overrun));
                end
            end
            if (req_valid && !req_stall)
                expected_steps.push_back(advance_pattern(req_item));
            // register writes take effect after this edge's item
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SEED:   seed_reg   = cfg_data;
                    CFG_BASE:   base_reg   = cfg_data;
                    CFG_LENGTH: length_reg = cfg_data;
                    default: ;
                endcase
            end
            outstanding <= expected_steps.size();
        end
    end

endmodule

/* verif/lcg_memory_pattern_tester_test.sv */
// The top makes stimulus and gives the verdict; pattern_step_checker predicts
// and compares every result. The top also plays the memory under test: while
// a write pass runs it stores each returned pattern byte at its address, and
// the following check pass reads those bytes back, now and then with a bit
// flipped, so that both mismatch values show up.
module lcg_memory_pattern_tester_test;
    import lcgmt_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;  // selector value with no meaning

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_CYCLES = 6;       // quiet time after the last result

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_item_t   req_item  = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_item_t   rsp_item;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_SEED;
    logic [31:0] cfg_data  = '0;

    int          error_count;
    int          outstanding;

    bit          pace_on    = 1'b1;  // random gaps and stalls on both sides
    bit          capture_on = 1'b0;  // write pass running: record into memory
    logic [31:0] cur_base   = '0;
    logic [31:0] cur_length = '0;
    logic [7:0]  memory_image [logic [31:0]];
    int          items_sent = 0;
    int unsigned cycle_count = 0;

    lcg_memory_pattern_tester u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pattern_step_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_item    (req_item),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_item    (rsp_item),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard stop if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("lcg_memory_pattern_tester_test: errors");
            $finish;
        end
    end

    // Result side: after each accepted result, hold stall for a random draw when pacing is on.
    initial
    begin : rsp_pacer
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                hold = pace_on ? $urandom_range(0, 7) : 0;
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                hold--;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Memory under test: write-pass results land here (start results write a
    // zero at base first, the first write step then overwrites it).
    always @(posedge clk)
    begin
        if (capture_on && rsp_valid && !rsp_stall && !rsp_item.overrun)
            memory_image[rsp_item.address] = rsp_item.pattern_byte;
    end

    // Called at a rising edge; returns at the edge the item was taken.
    // Valid stays high so back-to-back items need no second assignment.
    task automatic push_item(input logic [1:0] kind, input logic [7:0] data);
        int gap;
        gap = pace_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid          <= 1'b1;
        req_item.req_type  <= kind;
        req_item.read_byte <= data;
        do
            @(posedge clk);
        while (req_stall);
        items_sent++;
    endtask

    // Drop valid, wait for every result, then let the pipeline go quiet.
    task automatic settle();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Only called with the block idle (after settle or reset).
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_BASE)
            cur_base = value;
        else if (idx == CFG_LENGTH)
            cur_length = value;
    endtask

    // Byte read back from the memory image at base + offset, optionally
    // with one bit flipped to force a mismatch.
    function automatic logic [7:0] readback(input int unsigned offset, input bit corrupt);
        logic [31:0] addr;
        logic [7:0]  data;
        addr = cur_base + offset;
        data = memory_image.exists(addr) ? memory_image[addr] : 8'($urandom);
        if (corrupt)
            data = data ^ (8'd1 << $urandom_range(0, 7));
        return data;
    endfunction

    initial
    begin : stimulus
        int          steps;
        int          extra;
        int          burst;
        int          directed_count;
        logic [31:0] value;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // Reset values: zero length, so every step overruns.
        push_item(REQ_WRITE, 8'h00);
        push_item(REQ_CHECK, 8'hFF);
        push_item(REQ_UNUSED, 8'hFF);
        push_item(REQ_START, 8'hAA);     // address = base, read byte ignored
        push_item(REQ_WRITE, 8'h55);     // still overrun after a start
        settle();

        // Top seed, base two below the top so the address wraps to zero.
        write_register(CFG_SEED, 32'hFFFF_FFFF);
        write_register(CFG_BASE, 32'hFFFF_FFFE);
        write_register(CFG_LENGTH, 32'd3);
        capture_on = 1'b1;
        push_item(REQ_START, 8'h00);
        repeat (4) push_item(REQ_WRITE, 8'($urandom));   // last write overruns
        settle();
        capture_on = 1'b0;
        push_item(REQ_START, 8'hFF);
        push_item(REQ_CHECK, readback(0, 1'b0));
        push_item(REQ_CHECK, readback(1, 1'b1));         // bad byte
        push_item(REQ_UNUSED, 8'h00);                    // no effect mid-pass
        push_item(REQ_CHECK, readback(2, 1'b0));         // final byte
        push_item(REQ_CHECK, 8'h00);                     // past the end
        settle();

        // Zero seed and base, maximum length.
        write_register(CFG_SEED, 32'h0);
        write_register(CFG_BASE, 32'h0);
        write_register(CFG_LENGTH, 32'hFFFF_FFFF);
        push_item(REQ_START, 8'h00);
        push_item(REQ_WRITE, 8'h00);
        push_item(REQ_CHECK, 8'hFF);
        push_item(REQ_CHECK, 8'h00);
        settle();

        // Shrink the region under the running index: overruns, then a
        // one-byte region whose first byte is also the last.
        write_register(CFG_LENGTH, 32'd1);
        push_item(REQ_WRITE, 8'h00);
        push_item(REQ_CHECK, 8'hFF);
        push_item(REQ_START, 8'h00);
        push_item(REQ_CHECK, 8'h00);
        directed_count = items_sent;

        // ---- random part ----
        while (items_sent < directed_count + RANDOM_ITEMS)
        begin
            settle();
            pace_on = ($urandom_range(0, 3) != 0);

            if ($urandom_range(0, 2) != 0)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    case ($urandom_range(0, 5))
                        0:       value = 32'h0;
                        1:       value = 32'hFFFF_FFFF;
                        default: value = $urandom;
                    endcase
                    write_register(CFG_SEED, value);
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    case ($urandom_range(0, 5))
                        0:       value = 32'h0;
                        1:       value = 32'hFFFF_FFFF - $urandom_range(0, 20);
                        default: value = $urandom;
                    endcase
                    write_register(CFG_BASE, value);
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    case ($urandom_range(0, 19))
                        0:       value = 32'h0;
                        1:       value = 32'hFFFF_FFFF;
                        2:       value = $urandom;
                        default: value = $urandom_range(1, 32);
                    endcase
                    write_register(CFG_LENGTH, value);
                end
            end

            if ($urandom_range(0, 9) < 7)
            begin
                // Well-formed test: write pass, then check pass over the
                // same region, sometimes running a little past the end.
                if (cur_length <= 32'd40)
                begin
                    steps = int'(cur_length);
                    extra = $urandom_range(0, 2);
                end
                else
                begin
                    steps = $urandom_range(1, 24);
                    extra = 0;
                end
                capture_on = 1'b1;
                push_item(REQ_START, 8'($urandom));
                for (int i = 0; i < steps + extra; i++)
                    push_item(REQ_WRITE, 8'($urandom));
                settle();
                capture_on = 1'b0;
                push_item(REQ_START, 8'($urandom));
                for (int i = 0; i < steps + extra; i++)
                    push_item(REQ_CHECK, readback(i, $urandom_range(0, 5) == 0));
            end
            else
            begin
                // Noise: any selector, any read byte, no pass structure.
                burst = $urandom_range(6, 24);
                repeat (burst) push_item(2'($urandom_range(0, 3)), 8'($urandom));
            end
        end

        settle();
        if (error_count == 0 && outstanding == 0)
            $display("lcg_memory_pattern_tester_test: clean");
        else
            $display("lcg_memory_pattern_tester_test: errors");
        $finish;
    end

endmodule
